/* design/phong_light_shader_core_assert.svh */
// Assertion macros shared by the shader RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef PHONG_LIGHT_SHADER_CORE_ASSERT_SVH
`define PHONG_LIGHT_SHADER_CORE_ASSERT_SVH

// Same-cycle implication.
`define PLSC_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PLSC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/plsc_pkg.sv */
package plsc_pkg;

  // Three Q2.14 components, x in the low bits
  typedef logic [2:0][15:0] vec3_t;

  // Packed RGB pair, red in the top byte of each
  typedef struct packed {
    logic [23:0] light;
    logic [23:0] base;
  } color_t;

  // Item as it enters the geometry stages
  typedef struct packed {
    logic [7:0] bright;
    color_t     col;
    vec3_t      v;
    vec3_t      l;
    vec3_t      n;
  } shade_in_t;

  // Geometry result: diffuse term and clamped specular base
  typedef struct packed {
    logic [19:0] dif;
    logic [16:0] spec_base;
    color_t      col;
  } geom_out_t;

  // Power result
  typedef struct packed {
    logic [19:0] dif;
    logic [16:0] spec;
    color_t      col;
  } spec_out_t;

  localparam logic [16:0] SPEC_ONE     = 17'h10000;
  localparam logic [8:0]  WEIGHT_FULL  = 9'd256;
  localparam logic [8:0]  WEIGHT_RESET = 9'd228;
  // ceil(2^36 / 255): exact quotient for any 28-bit dividend
  localparam logic [28:0] DIV255_MUL   = 29'd269488145;

endpackage

/* design/plsc_geom.sv */
module plsc_geom (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plsc_pkg::shade_in_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output plsc_pkg::geom_out_t out_data_o
);
  import plsc_pkg::*;

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] vld_q, vld_d, adv;

  // stage 1: products L_i * N_i
  logic signed [31:0] ln_q [3];
  vec3_t              n1_q, l1_q, v1_q;
  color_t             col1_q;
  logic [7:0]         br1_q;
  // stage 2: L.N
  logic signed [32:0] dln_q;
  vec3_t              n2_q, l2_q, v2_q;
  color_t             col2_q;
  logic [7:0]         br2_q;
  // stage 3: a14 * N_i and diffuse numerator
  logic signed [34:0] an_q [3];
  logic [27:0]        difp_q;
  vec3_t              l3_q, v3_q;
  color_t             col3_q;
  // stage 4: reflected vector, diffuse quotient
  logic signed [22:0] r_q [3];
  logic [19:0]        dif4_q;
  vec3_t              v4_q;
  color_t             col4_q;
  // stage 5: products R_i * V_i
  logic signed [38:0] rv_q [3];
  logic [19:0]        dif5_q;
  color_t             col5_q;
  // stage 6: specular base
  geom_out_t          out_q;

  // Stall chain: a stage loads when empty or when its successor moves
  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_d = {vld_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (adv[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  // Combinational work of each stage
  logic signed [31:0] ln_d [3];
  logic signed [32:0] dln_d;
  logic signed [18:0] a14;
  logic signed [34:0] an_d [3];
  logic [27:0]        difp_d;
  logic signed [22:0] r_d [3];
  logic [56:0]        difq;
  logic signed [38:0] rv_d [3];
  logic signed [41:0] rv_sum, sdot;
  logic [28:0]        xf;
  logic [16:0]        sbase_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ln_d[i] = 32'($signed(in_data_i.l[i])) * 32'($signed(in_data_i.n[i]));
    end
    dln_d = 33'(ln_q[0]) + 33'(ln_q[1]) + 33'(ln_q[2]);

    // floor(L.N / 2^14), then 2 * a14 * N_i kept as a14 * N_i
    a14 = dln_q[32:14];
    for (int i = 0; i < 3; i++) begin
      an_d[i] = 35'(a14) * 35'($signed(n2_q[i]));
    end
    difp_d = (dln_q > 33'sd0) ? 28'(dln_q[31:12]) * 28'(br2_q) : '0;

    // floor(2 * a14 * N_i / 2^14) - L_i
    for (int i = 0; i < 3; i++) begin
      r_d[i] = 23'($signed(an_q[i][34:13])) - 23'($signed(l3_q[i]));
    end
    difq = 57'(difp_q) * 57'(DIV255_MUL);

    for (int i = 0; i < 3; i++) begin
      rv_d[i] = 39'(r_q[i]) * 39'($signed(v4_q[i]));
    end

    // s = -(R.V), clamped to [0, 1.0] in Q16
    rv_sum = 42'(rv_q[0]) + 42'(rv_q[1]) + 42'(rv_q[2]);
    sdot   = -rv_sum;
    xf     = sdot[40:12];
    if (sdot > 42'sd0) begin
      sbase_d = (xf > 29'(SPEC_ONE)) ? SPEC_ONE : xf[16:0];
    end else begin
      sbase_d = '0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      ln_q   <= ln_d;
      n1_q   <= in_data_i.n;
      l1_q   <= in_data_i.l;
      v1_q   <= in_data_i.v;
      col1_q <= in_data_i.col;
      br1_q  <= in_data_i.bright;
    end
    if (adv[1]) begin
      dln_q  <= dln_d;
      n2_q   <= n1_q;
      l2_q   <= l1_q;
      v2_q   <= v1_q;
      col2_q <= col1_q;
      br2_q  <= br1_q;
    end
    if (adv[2]) begin
      an_q   <= an_d;
      difp_q <= difp_d;
      l3_q   <= l2_q;
      v3_q   <= v2_q;
      col3_q <= col2_q;
    end
    if (adv[3]) begin
      r_q    <= r_d;
      dif4_q <= difq[55:36];
      v4_q   <= v3_q;
      col4_q <= col3_q;
    end
    if (adv[4]) begin
      rv_q   <= rv_d;
      dif5_q <= dif4_q;
      col5_q <= col4_q;
    end
    if (adv[5]) begin
      out_q.dif       <= dif5_q;
      out_q.spec_base <= sbase_d;
      out_q.col       <= col5_q;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStages-1];
  assign out_data_o  = out_q;

endmodule

/* design/plsc_spec.sv */
module plsc_spec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plsc_pkg::geom_out_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output plsc_pkg::spec_out_t out_data_o
);
  import plsc_pkg::*;

  localparam int unsigned NumStages = 4;

  // Q16 product, rounded half up
  function automatic logic [16:0] qmul(input logic [16:0] a, input logic [16:0] b);
    logic [34:0] p;
    p = 35'(a) * 35'(b) + 35'd32768;
    return p[32:16];
  endfunction

  logic [NumStages-1:0] vld_q, vld_d, adv;

  logic [16:0] x2_q, x4_q, x8_q, x4c_q;
  logic [19:0] dif_q [NumStages-1];
  color_t      col_q [NumStages-1];
  spec_out_t   out_q;

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_d = {vld_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (adv[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  // x^12 by squaring: x2, x4, x8, then x8 * x4
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      x2_q     <= qmul(in_data_i.spec_base, in_data_i.spec_base);
      dif_q[0] <= in_data_i.dif;
      col_q[0] <= in_data_i.col;
    end
    if (adv[1]) begin
      x4_q     <= qmul(x2_q, x2_q);
      dif_q[1] <= dif_q[0];
      col_q[1] <= col_q[0];
    end
    if (adv[2]) begin
      x8_q     <= qmul(x4_q, x4_q);
      x4c_q    <= x4_q;
      dif_q[2] <= dif_q[1];
      col_q[2] <= col_q[1];
    end
    if (adv[3]) begin
      out_q.spec <= qmul(x8_q, x4c_q);
      out_q.dif  <= dif_q[2];
      out_q.col  <= col_q[2];
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStages-1];
  assign out_data_o  = out_q;

endmodule

/* design/plsc_color.sv */
module plsc_color (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [8:0]          weight_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  plsc_pkg::spec_out_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [23:0]         out_data_o
);
  import plsc_pkg::*;

  localparam int unsigned NumStages = 5;

  // floor(p / 255), exact for p <= 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = 17'(p) + 17'(p[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  logic [NumStages-1:0] vld_q, vld_d, adv;

  logic [28:0] wd_q;
  logic [25:0] ws_q;
  color_t      col1_q, col2_q;
  logic [21:0] mix_q;
  logic [7:0]  c_q [3];
  logic [23:0] light3_q;
  logic [15:0] pl_q [3];
  logic [7:0]  out_q [3];

  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign vld_d = {vld_q[NumStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (adv[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  // Per-channel work; channel 0 is red, taken from the top byte
  logic [29:0] mix_sum;
  logic [29:0] cprod [3];
  logic [13:0] chi   [3];
  logic [7:0]  c_d   [3];
  logic [15:0] pl_d  [3];
  logic [7:0]  o_d   [3];

  always_comb begin
    mix_sum = 30'(wd_q) + 30'(ws_q);
    for (int i = 0; i < 3; i++) begin
      cprod[i] = 30'(col2_q.base[23-8*i -: 8]) * 30'(mix_q);
      chi[i]   = cprod[i][29:16];
      c_d[i]   = (chi[i] > 14'd255) ? 8'd255 : chi[i][7:0];
      pl_d[i]  = 16'(c_q[i]) * 16'(light3_q[23-8*i -: 8]);
      o_d[i]   = div255(pl_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    // weighted diffuse and specular shares
    if (adv[0]) begin
      wd_q   <= 29'(weight_i) * 29'(in_data_i.dif);
      ws_q   <= 26'(WEIGHT_FULL - weight_i) * 26'(in_data_i.spec);
      col1_q <= in_data_i.col;
    end
    if (adv[1]) begin
      mix_q  <= mix_sum[29:8];
      col2_q <= col1_q;
    end
    if (adv[2]) begin
      c_q      <= c_d;
      light3_q <= col2_q.light;
    end
    if (adv[3]) begin
      pl_q <= pl_d;
    end
    if (adv[4]) begin
      out_q <= o_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[NumStages-1];
  assign out_data_o  = {out_q[2], out_q[1], out_q[0]};

endmodule

/* design/phong_light_shader_core.sv */
// Phong shading of one surface hit for one light, diffuse plus specular.
//
// s_axis: one item per hit carrying N, L, V (signed Q2.14), base and light
// colors (packed RGB) and the light brightness. m_axis: one shaded RGB item
// per input item, in order. cfg: writes the 9-bit diffuse weight (1/256
// units, values above 256 act as 256); it is always ready and is meant to be
// written only while no item is in flight.
//
// Throughput is one item per cycle while m_axis does not stall. There are 6
// geometry stages (dot products, reflection, diffuse divide), 4 stages for the
// specular power (one Q16 square or product per stage) and 5 color stages. No
// stage chains two multiplies, and no multiply is wider than 32x32.
//
// Reset empties the pipeline and sets the weight to 228. When m_axis stalls,
// stages that hold items keep them; empty stages still fill, so s_axis keeps
// taking items until all 15 stages are occupied.
`include "phong_light_shader_core_assert.svh"

module phong_light_shader_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // normal_x/y/z, light_dir_x/y/z, view_x/y/z, base_color, light_color,
  // light_brightness
  input  logic [199:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_red, out_green, out_blue
  output logic [23:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [8:0]   cfg_data_i
);
  import plsc_pkg::*;

  logic [8:0] weight_q, weight_eff;

  // Diffuse weight register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      weight_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign weight_eff  = (weight_q > WEIGHT_FULL) ? WEIGHT_FULL : weight_q;

  // Unpack the input item
  shade_in_t in_pl;
  assign in_pl.n          = s_axis_tdata[47:0];
  assign in_pl.l          = s_axis_tdata[95:48];
  assign in_pl.v          = s_axis_tdata[143:96];
  assign in_pl.col.base   = s_axis_tdata[167:144];
  assign in_pl.col.light  = s_axis_tdata[191:168];
  assign in_pl.bright     = s_axis_tdata[199:192];

  logic      geom_vld, geom_rdy, spec_vld, spec_rdy;
  geom_out_t geom_pl;
  spec_out_t spec_pl;

  plsc_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_pl),
    .out_valid_o (geom_vld),
    .out_ready_i (geom_rdy),
    .out_data_o  (geom_pl)
  );

  plsc_spec u_spec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (geom_vld),
    .in_ready_o  (geom_rdy),
    .in_data_i   (geom_pl),
    .out_valid_o (spec_vld),
    .out_ready_i (spec_rdy),
    .out_data_o  (spec_pl)
  );

  plsc_color u_color (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .weight_i    (weight_eff),
    .in_valid_i  (spec_vld),
    .in_ready_o  (spec_rdy),
    .in_data_i   (spec_pl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // Checks
  `PLSC_ASSERT_NEXT(cfg_write_a, cfg_valid_i && cfg_ready_o, weight_q == $past(cfg_data_i), "weight write lost")
  `PLSC_ASSERT_IMPLY(full_stall_a, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input blocked without output stall")
  `PLSC_ASSERT_IMPLY(spec_range_a, spec_vld, spec_pl.spec <= SPEC_ONE, "specular term above 1.0")

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import plsc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 20;   // margin beyond the pipeline depth
  localparam int ITEMS_PER_PHASE = 100;
  localparam int N_PHASES = 9;

  typedef logic signed [15:0] q14_t;

  typedef struct {
    q14_t x;
    q14_t y;
    q14_t z;
  } v3_t;

  // One surface hit as the shader sees it
  typedef struct {
    v3_t         n;
    v3_t         l;
    v3_t         v;
    logic [23:0] base;
    logic [23:0] light;
    logic [7:0]  bright;
  } hit_t;

  // Directed row; px is used only when typed is set
  typedef struct {
    hit_t        h;
    bit          typed;
    logic [23:0] px;
  } row_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic [199:0] s_data = '0;
  logic         m_ready = 1'b0;
  logic         cfg_valid = 1'b0;
  logic [8:0]   cfg_data = '0;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic [23:0]  m_axis_tdata;
  logic         cfg_ready_o;

  // Pixels owed by the shader, oldest first: {blue, green, red}
  logic [23:0]  pending_px[$];
  logic [8:0]   weight_reg = WEIGHT_RESET;
  int           n_sent = 0;
  int           n_bad = 0;
  int           burst_left = 0;
  logic         hold_rx = 1'b0;
  logic [15:0]  rx_pat = 16'hFFFF;
  int           rx_left = 0;
  logic [8:0]   phase_wt [N_PHASES] = '{9'd256, 9'd0, 9'd511, 9'd257, 9'd1, 9'd255,
                                        9'd228, 9'd128, 9'd300};

  phong_light_shader_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // tdata fields from the lowest bit up: normal, light dir, view, base, light, brightness
  function automatic logic [199:0] pack_hit(hit_t h);
    return {h.bright, h.light, h.base, h.v.z, h.v.y, h.v.x,
            h.l.z, h.l.y, h.l.x, h.n.z, h.n.y, h.n.x};
  endfunction

  function automatic hit_t mk_hit(int nx, int ny, int nz, int lx, int ly, int lz,
                                  int vx, int vy, int vz, logic [23:0] base,
                                  logic [23:0] light, logic [7:0] bright);
    hit_t h;
    h.n = '{q14_t'(nx), q14_t'(ny), q14_t'(nz)};
    h.l = '{q14_t'(lx), q14_t'(ly), q14_t'(lz)};
    h.v = '{q14_t'(vx), q14_t'(vy), q14_t'(vz)};
    h.base = base;
    h.light = light;
    h.bright = bright;
    return h;
  endfunction

  // Shaded pixel for one hit under diffuse weight wt
  function automatic logic [23:0] shade_hit(hit_t h, logic [8:0] wt);
    longint nv [3];
    longint lv [3];
    longint vv [3];
    longint rv [3];
    longint dln, a14, sdot, dif, spec, x, x2, x4, x8, w, mix, c, bc, lc;
    logic [23:0] px;
    nv[0] = longint'(h.n.x); nv[1] = longint'(h.n.y); nv[2] = longint'(h.n.z);
    lv[0] = longint'(h.l.x); lv[1] = longint'(h.l.y); lv[2] = longint'(h.l.z);
    vv[0] = longint'(h.v.x); vv[1] = longint'(h.v.y); vv[2] = longint'(h.v.z);

    // diffuse: L.N in Q28, clamped at zero, scaled by brightness
    dln = lv[0] * nv[0] + lv[1] * nv[1] + lv[2] * nv[2];
    dif = 0;
    if (dln > 0) dif = ((dln >>> 12) * longint'(h.bright)) / 255;

    // reflect L about N, floor shifts throughout
    a14 = dln >>> 14;
    for (int i = 0; i < 3; i++) rv[i] = ((2 * a14 * nv[i]) >>> 14) - lv[i];
    sdot = -(rv[0] * vv[0] + rv[1] * vv[1] + rv[2] * vv[2]);

    // specular: base clamped to 1.0, 12th power by rounded Q16 squaring
    spec = 0;
    if (sdot > 0) begin
      x = sdot >>> 12;
      if (x > 65536) x = 65536;
      x2 = (x * x + 32768) >>> 16;
      x4 = (x2 * x2 + 32768) >>> 16;
      x8 = (x4 * x4 + 32768) >>> 16;
      spec = (x8 * x4 + 32768) >>> 16;
    end

    w = (wt > WEIGHT_FULL) ? longint'(WEIGHT_FULL) : longint'(wt);
    mix = (w * dif + (256 - w) * spec) >>> 8;

    // per channel: red is the top byte of the colors, lowest byte of the pixel
    for (int i = 0; i < 3; i++) begin
      bc = longint'(h.base[16 - 8 * i +: 8]);
      lc = longint'(h.light[16 - 8 * i +: 8]);
      c = (bc * mix) >>> 16;
      if (c > 255) c = 255;
      px[8 * i +: 8] = 8'((c * lc) / 255);
    end
    return px;
  endfunction

  function automatic real rnd_sym();
    return ($urandom_range(0, 20000) / 10000.0) - 1.0;
  endfunction

  function automatic v3_t unit_dir(real x, real y, real z);
    real m;
    v3_t r;
    m = $sqrt(x * x + y * y + z * z);
    if (m < 1.0e-6) begin
      x = 0.0; y = 0.0; z = 1.0; m = 1.0;
    end
    r.x = q14_t'($rtoi(x / m * 16384.0));
    r.y = q14_t'($rtoi(y / m * 16384.0));
    r.z = q14_t'($rtoi(z / m * 16384.0));
    return r;
  endfunction

  function automatic q14_t corner_q14();
    case ($urandom_range(0, 6))
      0: return -16'sd32768;
      1: return -16'sd16384;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      5: return 16'sd16384;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic hit_t draw_hit();
    hit_t h;
    int kind;
    real d, j, rx, ry, rz;
    kind = $urandom_range(0, 99);
    h.base = 24'($urandom_range(0, 24'hFFFFFF));
    h.light = 24'($urandom_range(0, 24'hFFFFFF));
    h.bright = 8'($urandom_range(0, 255));
    if (kind < 70) begin
      // unit vectors, mostly lit, view near the mirror direction
      h.n = unit_dir(rnd_sym(), rnd_sym(), rnd_sym());
      h.l = unit_dir(rnd_sym(), rnd_sym(), rnd_sym());
      d = (real'(h.n.x) * real'(h.l.x) + real'(h.n.y) * real'(h.l.y) +
           real'(h.n.z) * real'(h.l.z)) / 268435456.0;
      if (d < 0.0 && $urandom_range(0, 3) != 0) begin
        h.l = '{-h.l.x, -h.l.y, -h.l.z};
        d = -d;
      end
      rx = 2.0 * d * h.n.x / 16384.0 - h.l.x / 16384.0;
      ry = 2.0 * d * h.n.y / 16384.0 - h.l.y / 16384.0;
      rz = 2.0 * d * h.n.z / 16384.0 - h.l.z / 16384.0;
      case ($urandom_range(0, 3))
        0: j = 0.0;
        1: j = 0.05;
        2: j = 0.3;
        default: j = 1.5;
      endcase
      h.v = unit_dir(-rx + j * rnd_sym(), -ry + j * rnd_sym(), -rz + j * rnd_sym());
      if ($urandom_range(0, 7) == 0) h.base = 24'hFFFFFF;
      if ($urandom_range(0, 7) == 0) h.bright = 8'hFF;
    end else if (kind < 85) begin
      // raw bit patterns
      h.n = '{q14_t'($urandom_range(0, 65535)), q14_t'($urandom_range(0, 65535)),
              q14_t'($urandom_range(0, 65535))};
      h.l = '{q14_t'($urandom_range(0, 65535)), q14_t'($urandom_range(0, 65535)),
              q14_t'($urandom_range(0, 65535))};
      h.v = '{q14_t'($urandom_range(0, 65535)), q14_t'($urandom_range(0, 65535)),
              q14_t'($urandom_range(0, 65535))};
    end else begin
      // corner values everywhere
      h.n = '{corner_q14(), corner_q14(), corner_q14()};
      h.l = '{corner_q14(), corner_q14(), corner_q14()};
      h.v = '{corner_q14(), corner_q14(), corner_q14()};
      if ($urandom_range(0, 1) == 1) h.base = 24'hFFFFFF;
      if ($urandom_range(0, 1) == 1) h.light = '0;
      h.bright = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
    end
    return h;
  endfunction

  // Offer one item and hold it until taken; then continue the burst or idle
  task automatic offer_hit(input hit_t h, input bit typed, input logic [23:0] typed_px);
    int gap;
    s_valid <= 1'b1;
    s_data <= pack_hit(h);
    do @(posedge clk_i); while (!s_axis_tready);
    pending_px.push_back(typed ? typed_px : shade_hit(h, weight_reg));
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
                                                 $urandom_range(0, 20);
      gap = $urandom_range(1, 8);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain the pipeline, then write the diffuse weight
  task automatic set_weight(input logic [8:0] wv);
    s_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= wv;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    weight_reg = wv;
  endtask

  // Output side: check each pixel, stall on a rotating pattern
  always @(posedge clk_i) begin : rx_side
    logic [23:0] want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      if (pending_px.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected pixel %h", m_axis_tdata);
      end else begin
        want = pending_px.pop_front();
        if (want[7:0] !== m_axis_tdata[7:0] || want[15:8] !== m_axis_tdata[15:8] ||
            want[23:16] !== m_axis_tdata[23:16]) begin
          n_bad++;
          if (n_bad <= 10)
            $display("pixel mismatch: exp r/g/b %0d/%0d/%0d got %0d/%0d/%0d",
                     want[7:0], want[15:8], want[23:16], m_axis_tdata[7:0],
                     m_axis_tdata[15:8], m_axis_tdata[23:16]);
        end
      end
    end
    if (rx_left == 0) begin
      case ($urandom_range(0, 3))
        0: rx_pat = 16'hFFFF;
        1: rx_pat = 16'($urandom_range(0, 65535)) | 16'h0001;
        2: rx_pat = 16'h00FF;
        default: rx_pat = 16'hAAAA;
      endcase
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_pat = {rx_pat[0], rx_pat[15:1]};
      rx_left--;
    end
    m_ready <= rx_pat[0] & ~hold_rx;
  end

  // One long output hold mid-run so the pipeline fills and blocks input
  initial begin
    wait (n_sent >= 400);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("[phong_light_shader_core] ERROR");
    $finish;
  end

  initial begin : stim
    row_t plan[$];
    hit_t h;
    logic [8:0] wv;
    // typed rows hold at the reset weight of 228
    plan.push_back('{mk_hit(0, 0, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 8'hFF),
                     1'b1, 24'h000000});
    // head-on light, eye on the mirror ray: full white
    plan.push_back('{mk_hit(0, 0, 16384, 0, 0, 16384, 0, 0, -16384, 24'hFFFFFF,
                            24'hFFFFFF, 8'hFF), 1'b1, 24'hFFFFFF});
    plan.push_back('{mk_hit(0, 0, 16384, 0, 0, 16384, 0, 0, -16384, 24'h000000,
                            24'hFFFFFF, 8'hFF), 1'b1, 24'h000000});
    plan.push_back('{mk_hit(0, 0, 16384, 0, 0, 16384, 0, 0, -16384, 24'hFFFFFF,
                            24'h000000, 8'hFF), 1'b1, 24'h000000});
    // light behind the surface
    plan.push_back('{mk_hit(0, 0, 16384, 0, 0, -16384, 0, 0, -16384, 24'hFFFFFF,
                            24'hFFFFFF, 8'hFF), 1'b1, 24'h000000});
    // reflection away from the eye: diffuse share only
    plan.push_back('{mk_hit(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 24'hFF8000,
                            24'hFFFFFF, 8'hFF), 1'b1, 24'h0072E3});
    // remaining rows go through the predictor
    plan.push_back('{mk_hit(0, 0, 16384, 0, 0, 16384, 0, 0, -16384, 24'hFFFFFF,
                            24'hFFFFFF, 8'h00), 1'b0, 24'h0});
    plan.push_back('{mk_hit(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 24'hFFFFFF, 24'hFFFFFF, 8'hFF), 1'b0, 24'h0});
    plan.push_back('{mk_hit(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, 24'hFFFFFF, 24'hFFFFFF, 8'hFF), 1'b0, 24'h0});
    plan.push_back('{mk_hit(16384, 0, 0, 0, 16384, 0, 0, 0, -16384, 24'h808080,
                            24'hFFFFFF, 8'hFF), 1'b0, 24'h0});
    plan.push_back('{mk_hit(-32768, 32767, 0, 32767, -32768, 16384, -1, 1, 0, 24'h123456,
                            24'hFEDCBA, 8'h80), 1'b0, 24'h0});
    plan.push_back('{mk_hit(16'h5555, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'hAAAA,
                            16'h5555, 16'hAAAA, 16'h5555, 24'h555555, 24'hAAAAAA, 8'h55),
                     1'b0, 24'h0});
    plan.push_back('{mk_hit(16'hAAAA, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'h5555,
                            16'hAAAA, 16'h5555, 16'hAAAA, 24'hAAAAAA, 24'h555555, 8'hAA),
                     1'b0, 24'h0});
    plan.push_back('{mk_hit(0, 0, 16384, 11585, 0, 11585, 11585, 0, -11585, 24'hC0FFEE,
                            24'hFFFFFF, 8'hFF), 1'b0, 24'h0});
    plan.push_back('{mk_hit(0, 0, 16384, 0, 0, 16384, 0, 0, -16384, 24'h010101,
                            24'h010101, 8'h01), 1'b0, 24'h0});
    // oversized light and view: specular base clamps to 1.0
    plan.push_back('{mk_hit(0, 0, 16384, 0, 0, 32767, 0, 0, -32767, 24'h406080,
                            24'hFFFFFF, 8'hFF), 1'b0, 24'h0});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) offer_hit(plan[i].h, plan[i].typed, plan[i].px);

    for (int k = 0; k < N_PHASES; k++) begin
      wv = (k == 6 || k == 7) ? 9'($urandom_range(0, 511)) : phase_wt[k];
      set_weight(wv);
      repeat (ITEMS_PER_PHASE) begin
        h = draw_hit();
        offer_hit(h, 1'b0, 24'h0);
      end
    end

    s_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("[phong_light_shader_core] OK");
    end else begin
      $display("[phong_light_shader_core] ERROR");
    end
    $finish;
  end

endmodule
